[sv/wcec_pkg.sv]
// Shared constants and types for the windowed cell event counter.
`timescale 1ns / 1ps

package wcec_pkg;

	// Geometry and counter width
	localparam int NUM_CELLS   = 16;
	localparam int COUNT_BITS  = 16;
	localparam int QUEUE_DEPTH = 2;

	// Field widths fixed by the interface
	localparam int CELL_W   = 4;
	localparam int VLEVEL_W = 18;
	localparam int ILEVEL_W = 17;
	localparam int PERIOD_W = 16;

	// Derived widths
	localparam int CELL_AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int CELL_CW = $clog2(NUM_CELLS + 1);
	localparam int CMP_W   = (CELL_CW > CELL_W) ? CELL_CW : CELL_W;

	// Request decode
	localparam logic REQ_VISIT = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// Result kind codes
	localparam logic KIND_REPLY  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic {
		CMD_VISIT = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_kind_t;

	// Classified command passed from front to back
	typedef struct packed {
		cmd_kind_t           kind;
		logic                in_range;
		logic [CELL_W-1:0]   cell_id;
		logic [CELL_AW-1:0]  addr;
		logic                infected;
	} cmd_t;

	// Queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// One memory row per cell: counters by slot and published levels
	typedef struct packed {
		logic [2:0][COUNT_BITS-1:0] visit;
		logic [1:0][COUNT_BITS-1:0] infect;
		logic [VLEVEL_W-1:0]        pub_visit;
		logic [ILEVEL_W-1:0]        pub_infect;
	} row_t;

endpackage

[sv/windowed_cell_event_counter_top.sv]
// Top level of the windowed cell event counter.
//
// Input channel (in_valid / in_stall): req_type 0 is a visit to cell_req with
// the infected flag, req_type 1 is a period tick. Output channel (out_valid /
// out_stall): kind 0 is a visit reply, kind 1 one line of the period report.
// A visit gives one result carrying the levels published at the last tick;
// a tick gives one line per cell, last set on the final cell, then moves to
// the next period and clears the slots that period uses.
// A visit reply passes the queue, the memory read register and the result
// register; a visit holds the execution side for a memory read, then update
// and write-back; a tick walks the cell memory one row per cycle while the
// result register is free, through its single read and write port.
// A two-entry command queue decouples acceptance from execution, so items
// are taken while results wait. When the receiver stalls, the result register
// holds, execution pauses, and in_stall rises once the queue fills.
// Reset is asynchronous and active low: it clears the per-row valid bits, so
// all counters and published levels read as zero at once; no clearing pass.
`timescale 1ns / 1ps

module windowed_cell_event_counter_top import wcec_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [CELL_W-1:0]   cell_req,
	input  logic                infected,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                kind,
	output logic [CELL_W-1:0]   cell_index,
	output logic [VLEVEL_W-1:0] visit_level,
	output logic [ILEVEL_W-1:0] infection_level,
	output logic [PERIOD_W-1:0] period_number,
	output logic                last
);

	q_status_t q_status;
	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      head;

	// Accept and classify
	wcec_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.cell_req (cell_req),
		.infected (infected),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Buffer commands
	wcec_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	// Execute and emit results
	wcec_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.q_status        (q_status),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.cell_index      (cell_index),
		.visit_level     (visit_level),
		.infection_level (infection_level),
		.period_number   (period_number),
		.last            (last)
	);

endmodule

[sv/wcec_front.sv]
// Input side: accepts items and classifies them into commands.
`timescale 1ns / 1ps

module wcec_front import wcec_pkg::*; (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic [CELL_W-1:0] cell_req,
	input  logic              infected,
	input  q_status_t         q_status,
	output logic              push,
	output cmd_t              push_cmd
);

	logic [CMP_W-1:0] cell_ext;

	// Hold the sender off while the queue is full
	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	// Check the cell against the cell count
	assign cell_ext = CMP_W'(cell_req);

	// Classify the item
	always_comb begin
		push_cmd.cell_id  = cell_req;
		push_cmd.addr     = cell_ext[CELL_AW-1:0];
		push_cmd.infected = infected;
		push_cmd.in_range = cell_ext < CMP_W'(NUM_CELLS);
		unique case (req_type)
			REQ_VISIT: push_cmd.kind = CMD_VISIT;
			REQ_TICK:  push_cmd.kind = CMD_TICK;
			default:   push_cmd.kind = CMD_VISIT;
		endcase
	end

endmodule

[sv/wcec_queue.sv]
// Short command queue between the front and the back.
`timescale 1ns / 1ps

module wcec_queue import wcec_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t q_status
);

	localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t            entry_q [QUEUE_DEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign q_status.full  = count_q == QC_W'(QUEUE_DEPTH);
	assign q_status.empty = count_q == '0;
	assign do_push = push && !q_status.full;
	assign do_pop  = pop && !q_status.empty;
	assign head    = entry_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/wcec_back.sv]
// Execution side: cell memory, period state, and the result register.
`timescale 1ns / 1ps

module wcec_back import wcec_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                head,
	input  q_status_t           q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                kind,
	output logic [CELL_W-1:0]   cell_index,
	output logic [VLEVEL_W-1:0] visit_level,
	output logic [ILEVEL_W-1:0] infection_level,
	output logic [PERIOD_W-1:0] period_number,
	output logic                last
);

	localparam int VCMP_W = (COUNT_BITS + 2 > VLEVEL_W) ? COUNT_BITS + 2 : VLEVEL_W;
	localparam int ICMP_W = (COUNT_BITS + 1 > ILEVEL_W) ? COUNT_BITS + 1 : ILEVEL_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
	localparam logic [VLEVEL_W-1:0]   VLEVEL_MAX = '1;
	localparam logic [ILEVEL_W-1:0]   ILEVEL_MAX = '1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_CALC = 2'b10
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [CELL_AW-1:0]   walk_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [1:0]           slot3_q;
	logic                 slot2_q;
	logic [NUM_CELLS-1:0] row_valid_q;

	row_t                 mem [NUM_CELLS];
	row_t                 rd_row_q;
	logic                 rd_valid_q;

	logic                 out_valid_q;
	logic                 kind_q;
	logic [CELL_W-1:0]    cell_q;
	logic [VLEVEL_W-1:0]  vlevel_q;
	logic [ILEVEL_W-1:0]  ilevel_q;
	logic [PERIOD_W-1:0]  period_out_q;
	logic                 last_q;

	logic                 out_free;
	logic                 fire;
	logic                 is_tick;
	logic                 last_cell;
	logic                 rd_en;
	logic [CELL_AW-1:0]   rd_addr;
	logic                 wr_en;
	logic [CELL_AW-1:0]   wr_addr;
	row_t                 row;
	row_t                 wr_row;
	logic [1:0]           next3;
	logic                 next2;
	logic [VCMP_W-1:0]    vsum;
	logic [ICMP_W-1:0]    isum;
	logic [VLEVEL_W-1:0]  vsat;
	logic [ILEVEL_W-1:0]  isat;
	logic [CMP_W-1:0]     walk_ext;
	logic                 res_kind;
	logic [CELL_W-1:0]    res_cell;
	logic [VLEVEL_W-1:0]  res_vlevel;
	logic [ILEVEL_W-1:0]  res_ilevel;
	logic [PERIOD_W-1:0]  res_period;
	logic                 res_last;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] cnt,
		input logic inc);
		if (cnt == COUNT_MAX) begin
			return cnt;
		end
		return cnt + COUNT_BITS'(inc);
	endfunction

	// Control decode
	assign out_free  = !out_valid_q || !out_stall;
	assign fire      = (state_q == S_CALC) && out_free;
	assign is_tick   = cmd_q.kind == CMD_TICK;
	assign last_cell = walk_q == CELL_AW'(NUM_CELLS - 1);
	assign pop       = (state_q == S_IDLE) && !q_status.empty;
	assign next3     = (slot3_q == 2'd2) ? 2'd0 : slot3_q + 2'd1;
	assign next2     = ~slot2_q;

	// Read the next row: the command's cell, or the walk position during a tick
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = CELL_AW'(walk_q + 1'b1);
		if (pop) begin
			rd_en   = 1'b1;
			rd_addr = (head.kind == CMD_TICK) ? '0 : head.addr;
		end else if (fire && is_tick && !last_cell) begin
			rd_en = 1'b1;
		end
	end

	// Rows that were never written since reset read as zero
	assign row = rd_valid_q ? rd_row_q : '0;

	// Sum slots and clamp to the level widths
	always_comb begin
		vsum = VCMP_W'(row.visit[0]) + VCMP_W'(row.visit[1]) + VCMP_W'(row.visit[2]);
		isum = ICMP_W'(row.infect[0]) + ICMP_W'(row.infect[1]);
		vsat = (vsum > VCMP_W'(VLEVEL_MAX)) ? VLEVEL_MAX : vsum[VLEVEL_W-1:0];
		isat = (isum > ICMP_W'(ILEVEL_MAX)) ? ILEVEL_MAX : isum[ILEVEL_W-1:0];
	end

	// Build the write-back row and the result
	assign walk_ext = CMP_W'(walk_q);
	always_comb begin
		wr_row = row;
		if (is_tick) begin
			wr_row.pub_visit     = vsat;
			wr_row.pub_infect    = isat;
			wr_row.visit[next3]  = '0;
			wr_row.infect[next2] = '0;
			wr_addr    = walk_q;
			wr_en      = fire;
			res_kind   = KIND_REPORT;
			res_cell   = walk_ext[CELL_W-1:0];
			res_vlevel = vsat;
			res_ilevel = isat;
			res_period = period_q;
			res_last   = last_cell;
		end else begin
			wr_row.visit[slot3_q]  = sat_inc(row.visit[slot3_q], 1'b1);
			wr_row.infect[slot2_q] = sat_inc(row.infect[slot2_q], cmd_q.infected);
			wr_addr    = cmd_q.addr;
			wr_en      = fire && cmd_q.in_range;
			res_kind   = KIND_REPLY;
			res_cell   = cmd_q.cell_id;
			res_vlevel = cmd_q.in_range ? row.pub_visit : '0;
			res_ilevel = cmd_q.in_range ? row.pub_infect : '0;
			res_period = '0;
			res_last   = 1'b1;
		end
	end

	// Cell memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q   <= mem[rd_addr];
			rd_valid_q <= row_valid_q[rd_addr];
		end
	end

	// Sequence commands, track period and slots, mark written rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			walk_q      <= '0;
			period_q    <= '0;
			slot3_q     <= '0;
			slot2_q     <= 1'b0;
			row_valid_q <= '0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						walk_q  <= '0;
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (fire) begin
						if (is_tick && !last_cell) begin
							walk_q <= walk_q + 1'b1;
						end else begin
							state_q <= S_IDLE;
							if (is_tick) begin
								period_q <= period_q + 1'b1;
								slot3_q  <= next3;
								slot2_q  <= next2;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Latch the command taken from the queue
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
	end

	// Result register: load on fire, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q       <= res_kind;
			cell_q       <= res_cell;
			vlevel_q     <= res_vlevel;
			ilevel_q     <= res_ilevel;
			period_out_q <= res_period;
			last_q       <= res_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign cell_index      = cell_q;
	assign visit_level     = vlevel_q;
	assign infection_level = ilevel_q;
	assign period_number   = period_out_q;
	assign last            = last_q;

endmodule
